### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n to be visible in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HCC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define HCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hdl/hcc_pkg.sv
// Shared constants and controller/datapath interface types.
// No dependencies; used by every module of the histogram block.
`default_nettype none

package hcc_pkg;

	localparam int NUM_BINS = 2048;
	localparam int BIN_W    = $clog2(NUM_BINS);   // bin address
	localparam int IDX_W    = BIN_W + 1;          // walk index, reaches NUM_BINS
	localparam int LAT_W    = 16;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 64;

	// operation codes
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // input beat accepted: load bin, end, clear walk
		logic clr_wr;    // write zero at the walk index (clearing pass)
		logic rec_rd;    // read counter of the captured bin
		logic rec_wr;    // write back counter + 1
		logic walk;      // read next bin of a query walk
		logic out_load;  // move the sum into the output register
	} hcc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;  // clearing pass at the last bin
		logic walk_done; // walk index reached the capped limit
		logic rd_pend;   // a walk read is still in flight
		logic out_free;  // output register can take a new beat
	} hcc_sts_t;

endpackage

`default_nettype wire

### hdl/hcc_dp.sv
// Datapath: bin counter memory, read-modify-write, query walk and output register.
// Depends on hcc_pkg; sequenced by hcc_ctrl.
`default_nettype none

module hcc_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire hcc_pkg::hcc_cmd_t          cmd,
	output hcc_pkg::hcc_sts_t               sts,
	input  wire logic [hcc_pkg::LAT_W-1:0]  latency_ms,
	input  wire logic [hcc_pkg::LAT_W-1:0]  limit_ms,
	output logic [hcc_pkg::SUM_W-1:0]       below_count,
	output logic                            out_valid,
	input  wire logic                       out_stall
);

	logic [hcc_pkg::CNT_W-1:0] mem [hcc_pkg::NUM_BINS];
	logic [hcc_pkg::CNT_W-1:0] rd_q;
	logic [hcc_pkg::BIN_W-1:0] bin_q;
	logic [hcc_pkg::IDX_W-1:0] end_q;
	logic [hcc_pkg::IDX_W-1:0] idx_q;
	logic [hcc_pkg::SUM_W-1:0] acc_q;
	logic [hcc_pkg::SUM_W-1:0] below_count_q;
	logic                      vld_s1;
	logic                      out_valid_q;

	logic [hcc_pkg::BIN_W-1:0] bin_d;
	logic [hcc_pkg::IDX_W-1:0] end_d;
	logic                      walk_rd;
	logic                      mem_re;
	logic [hcc_pkg::BIN_W-1:0] rd_addr;
	logic                      mem_we;
	logic [hcc_pkg::BIN_W-1:0] wr_addr;
	logic [hcc_pkg::CNT_W-1:0] wr_data;

	// clamp latency to the last bin, cap limit at the bin count
	always_comb begin
		if (latency_ms >= hcc_pkg::LAT_W'(hcc_pkg::NUM_BINS - 1)) begin
			bin_d = hcc_pkg::BIN_W'(hcc_pkg::NUM_BINS - 1);
		end else begin
			bin_d = latency_ms[hcc_pkg::BIN_W-1:0];
		end
		if (limit_ms > hcc_pkg::LAT_W'(hcc_pkg::NUM_BINS)) begin
			end_d = hcc_pkg::IDX_W'(hcc_pkg::NUM_BINS);
		end else begin
			end_d = limit_ms[hcc_pkg::IDX_W-1:0];
		end
	end

	// memory port selection
	assign walk_rd = cmd.walk && !sts.walk_done;
	assign mem_re  = cmd.rec_rd || walk_rd;
	assign rd_addr = walk_rd ? idx_q[hcc_pkg::BIN_W-1:0] : bin_q;
	assign mem_we  = cmd.clr_wr || cmd.rec_wr;
	assign wr_addr = cmd.clr_wr ? idx_q[hcc_pkg::BIN_W-1:0] : bin_q;
	assign wr_data = cmd.clr_wr ? '0 : rd_q + hcc_pkg::CNT_W'(1);

	// counter memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// captured item and running sum
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bin_q <= bin_d;
			end_q <= end_d;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + hcc_pkg::SUM_W'(rd_q);
		end
		if (cmd.out_load) begin
			below_count_q <= acc_q;
		end
	end

	// walk / clear index, read-valid flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.clr_wr || walk_rd) begin
				idx_q <= idx_q + hcc_pkg::IDX_W'(1);
			end
			vld_s1 <= walk_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last  = (idx_q[hcc_pkg::BIN_W-1:0] == hcc_pkg::BIN_W'(hcc_pkg::NUM_BINS - 1));
	assign sts.walk_done = (idx_q == end_q);
	assign sts.rd_pend   = vld_s1;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign below_count = below_count_q;
	assign out_valid   = out_valid_q;

endmodule

`default_nettype wire

### hdl/hcc_ctrl.sv
// Controller: clearing pass, record read-modify-write and query walk sequencing.
// Depends on hcc_pkg; drives hcc_dp through command/status structs.
`default_nettype none

module hcc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	output hcc_pkg::hcc_cmd_t      cmd,
	input  wire hcc_pkg::hcc_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REC_RD,
		ST_REC_WR,
		ST_QRY
	} state_t;

	state_t state_q;
	logic   accept;
	logic   qry_end;

	assign accept  = in_valid && (state_q == ST_IDLE);
	assign qry_end = sts.walk_done && !sts.rd_pend && sts.out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (operation == hcc_pkg::OP_QUERY) ? ST_QRY : ST_REC_RD;
					end
				end
				ST_REC_RD: state_q <= ST_REC_WR;
				ST_REC_WR: state_q <= ST_IDLE;
				ST_QRY: begin
					if (qry_end) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.clr_wr   = (state_q == ST_CLEAR);
		cmd.rec_rd   = (state_q == ST_REC_RD);
		cmd.rec_wr   = (state_q == ST_REC_WR);
		cmd.walk     = (state_q == ST_QRY);
		cmd.out_load = (state_q == ST_QRY) && qry_end;
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hdl/latency_histogram_cumulative_count_top.sv
// Latency histogram with cumulative count: top level.
// Depends on hcc_pkg, hcc_ctrl and hcc_dp.
//
// Input channel (in_valid/in_stall): one beat carries operation, latency_ms
// and limit_ms. A beat is taken when in_valid is high and in_stall is low.
// Record (operation 0) adds one to the 32-bit counter of bin
// min(latency_ms, 2047); it yields no output beat and keeps in_stall high
// through the read and write states after the beat (one read-modify-write
// on the counter memory).
// Query (operation 1) sums the bins below N = min(limit_ms, 2048) into a 64-bit
// result; the walk reads one bin per cycle from the single memory read port,
// and the sum moves into the output register once the walk has reached N,
// the last read has been added and the output register can take a new beat.
// Output channel (out_valid/out_stall): below_count sits in an output
// register and holds while out_stall is high; records keep being taken while
// a result waits, and only a query's final hand-off waits for the slot.
// Reset: after arst_n releases, a clearing pass zeroes all 2048 counters,
// one per cycle, with in_stall high for those 2048 cycles.
`default_nettype none

module latency_histogram_cumulative_count_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      operation,
	input  wire logic [hcc_pkg::LAT_W-1:0] latency_ms,
	input  wire logic [hcc_pkg::LAT_W-1:0] limit_ms,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [hcc_pkg::SUM_W-1:0]      below_count
);

	hcc_pkg::hcc_cmd_t cmd;
	hcc_pkg::hcc_sts_t sts;

	hcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.cmd       (cmd),
		.sts       (sts)
	);

	hcc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.latency_ms  (latency_ms),
		.limit_ms    (limit_ms),
		.below_count (below_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

endmodule

`default_nettype wire

### hdl/hcc_checker.sv
// Port-level checker for the histogram top level, attached by bind.
// Depends on hcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hcc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      operation,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [hcc_pkg::SUM_W-1:0] below_count
);

	logic in_beat;
	logic rec_beat;

	assign in_beat  = in_valid && !in_stall;
	assign rec_beat = in_beat && (operation == hcc_pkg::OP_RECORD);

	// stalled result beat holds
	`HCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(below_count))

	// one item at a time: busy right after a beat is taken
	`HCC_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall)

	// a record never produces a result beat
	`HCC_ASSERT_NEXT(a_record_silent, rec_beat, !$rose(out_valid))

	// a new result appears only as the query hands off and the input reopens
	`HCC_ASSERT_IMPLY(a_result_idle, $rose(out_valid), !in_stall)

endmodule

bind latency_histogram_cumulative_count_top hcc_checker u_hcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.operation   (operation),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.below_count (below_count)
);

`default_nettype wire

### sim/testbench.sv
// Testbench for latency_histogram_cumulative_count_top: record and query beats
// checked against a shadow copy of the bin counters. Depends on hcc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int  CYCLE_LIMIT = 6_000_000;
	localparam int  RANDOM_BEATS = 800;
	localparam int  TAIL_CYCLES = 20;
	localparam int  OWED_DEPTH = 16;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          operation;
	logic [hcc_pkg::LAT_W-1:0]     latency_ms;
	logic [hcc_pkg::LAT_W-1:0]     limit_ms;
	logic                          out_valid;
	logic                          out_stall;
	logic [hcc_pkg::SUM_W-1:0]     below_count;

	// shadow histogram and ring of sums still owed by the block
	logic [hcc_pkg::CNT_W-1:0]     shadow_bins [hcc_pkg::NUM_BINS];
	logic [hcc_pkg::SUM_W-1:0]     owed_ring [OWED_DEPTH];
	int                            owed_wr = 0;
	int                            owed_rd = 0;
	logic [hcc_pkg::SUM_W-1:0]     owed_count;
	int                            mismatch_count = 0;
	int                            cycle_count = 0;
	logic                          quiet;

	latency_histogram_cumulative_count_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.latency_ms  (latency_ms),
		.limit_ms    (limit_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.below_count (below_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// bump the bin of one latency; the last bin takes everything beyond
	function automatic void tally_latency(input logic [hcc_pkg::LAT_W-1:0] lat);
		int bin;
		bin = (lat > hcc_pkg::NUM_BINS - 1) ? hcc_pkg::NUM_BINS - 1 : int'(lat);
		shadow_bins[bin] = shadow_bins[bin] + 1'b1;
	endfunction

	// sum of the bins below the limit, limit capped at the bin count
	function automatic logic [hcc_pkg::SUM_W-1:0] predict_below_count(
			input logic [hcc_pkg::LAT_W-1:0] lim);
		logic [hcc_pkg::SUM_W-1:0] total;
		int top;
		total = '0;
		top = (lim > hcc_pkg::NUM_BINS) ? hcc_pkg::NUM_BINS : int'(lim);
		for (int i = 0; i < top; i++)
			total = total + hcc_pkg::SUM_W'(shadow_bins[i]);
		return total;
	endfunction

	// append one owed sum to the ring
	task automatic owe_sum(input logic [hcc_pkg::SUM_W-1:0] sum);
		owed_ring[owed_wr % OWED_DEPTH] = sum;
		owed_wr = owed_wr + 1;
	endtask

	// drive one beat at the falling edge, hold it until taken, then update the shadow
	task automatic send_beat(input logic op, input logic [hcc_pkg::LAT_W-1:0] lat,
			input logic [hcc_pkg::LAT_W-1:0] lim);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		latency_ms <= lat;
		limit_ms   <= lim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == hcc_pkg::OP_RECORD)
			tally_latency(lat);
		else
			owe_sum(predict_below_count(lim));
	endtask

	// hold off the sender until every owed sum has come out
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_wr != owed_rd)
			@(posedge clk);
	endtask

	// queries on a store that is still all zero
	task automatic test_empty_store();
		send_beat(hcc_pkg::OP_QUERY, 16'h0000, 16'd0);
		send_beat(hcc_pkg::OP_QUERY, 16'hFFFF, 16'd2048);
		send_beat(hcc_pkg::OP_QUERY, 16'h0000, 16'hFFFF);
	endtask

	// latencies at and past the last bin, limits around zero and the bin count
	task automatic test_bin_edges();
		send_beat(hcc_pkg::OP_RECORD, 16'd0, 16'hFFFF);
		send_beat(hcc_pkg::OP_RECORD, 16'd1, 16'h0000);
		send_beat(hcc_pkg::OP_RECORD, 16'd1, 16'hAAAA);
		send_beat(hcc_pkg::OP_RECORD, 16'd2046, 16'h5555);
		send_beat(hcc_pkg::OP_RECORD, 16'd2047, 16'd1);
		send_beat(hcc_pkg::OP_RECORD, 16'd2048, 16'd2048);
		send_beat(hcc_pkg::OP_RECORD, 16'hFFFF, 16'd0);
		send_beat(hcc_pkg::OP_QUERY, 16'hFFFF, 16'd0);
		send_beat(hcc_pkg::OP_QUERY, 16'h0000, 16'd1);
		send_beat(hcc_pkg::OP_QUERY, 16'h5555, 16'd2);
		send_beat(hcc_pkg::OP_QUERY, 16'hAAAA, 16'd2046);
		send_beat(hcc_pkg::OP_QUERY, 16'd2047, 16'd2047);
		send_beat(hcc_pkg::OP_QUERY, 16'd0, 16'd2048);
		send_beat(hcc_pkg::OP_QUERY, 16'd0, 16'd2049);
		send_beat(hcc_pkg::OP_QUERY, 16'd1, 16'hFFFF);
	endtask

	// a query followed by a full drain, then one more beat into the idle block
	task automatic test_drain_pause();
		send_beat(hcc_pkg::OP_QUERY, 16'h1234, 16'd3);
		pause_until_drained();
		send_beat(hcc_pkg::OP_QUERY, 16'hFFFF, 16'd2048);
		pause_until_drained();
	endtask

	// random mix; latencies mostly low so small queries see nonzero sums,
	// limits mostly small since a query walks one bin per cycle
	task automatic test_random_mix(input int beats);
		logic                      op;
		logic [hcc_pkg::LAT_W-1:0] lat;
		logic [hcc_pkg::LAT_W-1:0] lim;
		int                        roll;
		for (int n = 0; n < beats; n++) begin
			quiet = (n >= beats * 3 / 8) && (n < beats * 9 / 16);
			op = ($urandom_range(99) < 40) ? hcc_pkg::OP_QUERY : hcc_pkg::OP_RECORD;
			roll = $urandom_range(99);
			lat = hcc_pkg::LAT_W'($urandom);
			if (roll < 50)
				lat = hcc_pkg::LAT_W'($urandom_range(0, 80));
			else if (roll < 75)
				lat = hcc_pkg::LAT_W'($urandom_range(0, 2100));
			roll = $urandom_range(99);
			lim = hcc_pkg::LAT_W'($urandom);
			if (roll < 85)
				lim = hcc_pkg::LAT_W'($urandom_range(0, 64));
			else if (roll < 95)
				lim = hcc_pkg::LAT_W'($urandom_range(0, 2100));
			send_beat(op, lat, lim);
			if (op == hcc_pkg::OP_QUERY && $urandom_range(99) < 2)
				pause_until_drained();
		end
		quiet = 1'b0;
	endtask

	// receiver stalls at random, except during the quiet stretch
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 6);
	end

	// compare each result beat with the oldest owed sum
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_wr == owed_rd) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("unexpected result beat: below_count=%0d", below_count);
			end else begin
				owed_count = owed_ring[owed_rd % OWED_DEPTH];
				owed_rd = owed_rd + 1;
				if (below_count !== owed_count) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("below_count mismatch: expected %0d, got %0d",
							owed_count, below_count);
				end
			end
		end
	end

	// watchdog; covers the clearing pass and every query walking all bins
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = hcc_pkg::OP_RECORD;
		latency_ms     = '0;
		limit_ms       = '0;
		quiet          = 1'b0;
		for (int i = 0; i < hcc_pkg::NUM_BINS; i++)
			shadow_bins[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// counter wrap needs 2^32 records and is out of reach here;
		// the shadow counters still wrap at 32 bits
		test_empty_store();
		test_bin_edges();
		test_drain_pause();
		test_random_mix(RANDOM_BEATS);

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_wr == owed_rd)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/hcc_pkg.sv
hdl/hcc_dp.sv
hdl/hcc_ctrl.sv
hdl/latency_histogram_cumulative_count_top.sv
hdl/hcc_checker.sv
sim/testbench.sv
